// ===== hw/rtl/spectral_peak_normalizer_defines.svh =====
// Assertion macros shared by the checker files of the spectral peak normalizer.
`ifndef SPECTRAL_PEAK_NORMALIZER_DEFINES_SVH
`define SPECTRAL_PEAK_NORMALIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spn_pkg.sv =====
// Shared types and constants of the spectral peak normalizer.
package spn_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int MAG_W      = 32;
  localparam int GAIN_W     = 32;
  localparam int IDX_W      = 11;
  localparam int CFG_DATA_W = 32;
  localparam int RATIO_W    = 31;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kinds.
  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Register indexes.
  localparam logic REG_FIRST_STEP = 1'b0;
  localparam logic REG_GRID_RATIO = 1'b1;

  localparam logic [CFG_DATA_W-1:0] FIRST_STEP_RST = 32'd3579139;
  localparam logic [RATIO_W-1:0]    GRID_RATIO_RST = 31'd1086405535;
  localparam logic [GAIN_W-1:0]     GAIN_UNITY     = 32'h0100_0000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] ONE_Q24     = 64'd1 << 24;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_start;
    logic rd_mul;
    logic out_read;
    logic an_init;
    logic pt_init;
    logic issue;
    logic mag;
    logic sq;
    logic root_start;
    logic pt_done;
    logic div_start;
    logic gain_load;
    logic out_an;
  } spn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tap_last;
    logic pipe_busy;
    logic root_busy;
    logic grid_last;
    logic div_busy;
  } spn_sts_t;

endpackage

// ===== hw/rtl/spectral_peak_normalizer.sv =====
// Spectral peak normalizer. A load transaction stores one Q1.23 sample; loads can
// follow back to back. A load marked last starts the analysis, during which no
// transaction is taken: for each of the GRID_POINTS frequencies the N stored samples
// stream through the sine table and the two multipliers, one sample per cycle, then
// a 32-step square root runs, and the gain divider runs at the end. A read
// transaction passes through the store read, the gain multiply and the result
// register. The result register lets a new load be taken while the previous result
// still waits on out_stall.
module spectral_peak_normalizer import spn_pkg::*; #(
  parameter int MAX_TAPS         = 2048,
  parameter int GRID_POINTS      = 512,
  parameter int TRIG_TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  input  logic [IDX_W-1:0]           in_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_result_kind,
  output logic [MAG_W-1:0]           out_peak_mag,
  output logic [GAIN_W-1:0]          out_gain,
  output logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  spn_cmd_t cmd;
  spn_sts_t sts;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  spn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  spn_datapath #(
    .MAX_TAPS         (MAX_TAPS),
    .GRID_POINTS      (GRID_POINTS),
    .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample       (in_sample),
    .in_last         (in_last),
    .in_index        (in_index),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_result_kind (out_result_kind),
    .out_peak_mag    (out_peak_mag),
    .out_gain        (out_gain),
    .out_sample      (out_sample)
  );

endmodule

// ===== hw/rtl/spn_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module spn_isqrt import spn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] x_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [35:0] rem_t;
  logic [35:0] trial;
  logic        ge;

  // One result bit per step: compare the partial remainder with 4*root+1.
  always_comb begin
    rem_t = {rem_r, x_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
    ge    = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[61:0], 2'b00};
      rem_r  <= ge ? 34'(rem_t - trial) : rem_t[33:0];
      root_r <= {root_r[30:0], ge};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/spn_div.sv =====
// Restoring divider for the gain: round(2^44 / divisor), one quotient bit per cycle.
module spn_div import spn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MAG_W-1:0]  divisor,
  output logic              busy,
  output logic [44:0]       quot
);

  logic [44:0]      d_r;
  logic [44:0]      q_r;
  logic [31:0]      rem_r;
  logic [31:0]      dvs_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic [32:0]      rem_t;
  logic             ge;

  always_comb begin
    rem_t = {rem_r, d_r[44]};
    ge    = rem_t >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd44) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The dividend carries half the divisor so that the quotient is rounded.
  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= (45'd1 << 44) + 45'(divisor >> 1);
      q_r   <= '0;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      d_r   <= {d_r[43:0], 1'b0};
      q_r   <= {q_r[43:0], ge};
      rem_r <= ge ? 32'(rem_t - {1'b0, dvs_r}) : rem_t[31:0];
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

// ===== hw/rtl/spn_datapath.sv =====
// Datapath: sample store, DTFT pipeline, magnitude, grid stepping, gain and read scaling.
module spn_datapath import spn_pkg::*; #(
  parameter int MAX_TAPS         = 2048,
  parameter int GRID_POINTS      = 512,
  parameter int TRIG_TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spn_cmd_t                   cmd,
  output spn_sts_t                   sts,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  input  logic [IDX_W-1:0]           in_index,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       out_result_kind,
  output logic [MAG_W-1:0]           out_peak_mag,
  output logic [GAIN_W-1:0]          out_gain,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int CW     = AW + 1;
  localparam int GW     = $clog2(GRID_POINTS);
  localparam int TW     = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int PW     = 31 + TW;
  localparam int ACC_W  = 49 + AW;
  localparam int PROD_W = SAMPLE_W + 26;
  localparam int AMW    = ACC_W - 27;
  localparam int IXW    = (CW > IDX_W) ? CW : IDX_W;
  localparam int RP_W   = SAMPLE_W + GAIN_W + 1;

  typedef logic [24:0] sine_rom_t [TRIG_TABLE_DEPTH + 1];

  // Quarter-wave sine table in Q1.24, built from a truncated Taylor series.
  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] f;
    logic [63:0] s;
    for (int i = 0; i <= TRIG_TABLE_DEPTH; i++) begin
      th = (64'(i) * HALF_PI_Q30 + 64'(TRIG_TABLE_DEPTH / 2)) / 64'(TRIG_TABLE_DEPTH);
      t2 = (th * th) >> 30;
      f  = ONE_Q30;
      for (int k = 6; k >= 1; k--) begin
        f = ONE_Q30 - (((t2 * f) >> 30) / 64'((2 * k) * (2 * k + 1)));
      end
      s = (th * f) >> 30;
      if (s > ONE_Q30) begin
        s = ONE_Q30;
      end
      s = (s + 64'd32) >> 6;
      if (s > ONE_Q24) begin
        s = ONE_Q24;
      end
      rom[i] = s[24:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Table address and sign for a phase: quadrant mirrors the index and negates.
  function automatic logic [TW:0] trig_addr(input logic [31:0] ph);
    logic [PW-1:0] prod;
    logic [TW:0]   raw;
    logic [TW-1:0] idx;
    prod = PW'(ph[29:0]) * PW'(TRIG_TABLE_DEPTH) + (PW'(1) << 29);
    raw  = prod[PW-1:30];
    if (raw > (TW+1)'(TRIG_TABLE_DEPTH)) begin
      raw = (TW+1)'(TRIG_TABLE_DEPTH);
    end
    idx = raw[TW-1:0];
    if (ph[30]) begin
      idx = TW'(TRIG_TABLE_DEPTH) - idx;
    end
    return {ph[31], idx};
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] step0_r;
  logic [RATIO_W-1:0]    ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step0_r <= FIRST_STEP_RST;
      ratio_r <= GRID_RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_STEP: step0_r <= cfg_data;
        REG_GRID_RATIO: ratio_r <= cfg_data[RATIO_W-1:0];
        default:        step0_r <= step0_r;
      endcase
    end
  end

  // Response length and the closed flag set by a last load.
  logic [CW-1:0] count_r;
  logic          closed_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  always_comb begin
    wr_en   = cmd.load && (closed_r || (count_r < CW'(MAX_TAPS)));
    wr_addr = closed_r ? '0 : count_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      closed_r <= 1'b0;
    end else if (cmd.load) begin
      closed_r <= in_last;
      if (closed_r) begin
        count_r <= CW'(1);
      end else if (count_r < CW'(MAX_TAPS)) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Sample store: one write port, one registered read port.
  logic signed [SAMPLE_W-1:0] mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] mem_q_r;
  logic [AW-1:0]              tap_n_r;
  logic [AW-1:0]              rd_addr;

  assign rd_addr = cmd.issue ? tap_n_r : AW'(in_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_sample;
    end
    mem_q_r <= mem[rd_addr];
  end

  // Tap counter and phase accumulator of the current grid point.
  logic [31:0] phase_r;
  logic [31:0] step_r;
  logic [TW:0] sin_a_r;
  logic [TW:0] cos_a_r;
  logic        v0_r;
  logic        v1_r;
  logic        v2_r;

  always_ff @(posedge clk) begin
    if (cmd.pt_init) begin
      tap_n_r <= '0;
      phase_r <= '0;
    end else if (cmd.issue) begin
      tap_n_r <= tap_n_r + AW'(1);
      phase_r <= phase_r + step_r;
    end
    sin_a_r <= trig_addr(phase_r);
    cos_a_r <= trig_addr(phase_r + 32'h4000_0000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Table lookup stage.
  logic [24:0]                sin_v_r;
  logic [24:0]                cos_v_r;
  logic                       sin_n_r;
  logic                       cos_n_r;
  logic signed [SAMPLE_W-1:0] h1_r;

  always_ff @(posedge clk) begin
    sin_v_r <= SINE_ROM[sin_a_r[TW-1:0]];
    cos_v_r <= SINE_ROM[cos_a_r[TW-1:0]];
    sin_n_r <= sin_a_r[TW];
    cos_n_r <= cos_a_r[TW];
    h1_r    <= mem_q_r;
  end

  // Product stage.
  logic signed [25:0]       sin_s;
  logic signed [25:0]       cos_s;
  logic signed [PROD_W-1:0] pr_r;
  logic signed [PROD_W-1:0] pi_r;

  always_comb begin
    sin_s = sin_n_r ? -$signed({1'b0, sin_v_r}) : $signed({1'b0, sin_v_r});
    cos_s = cos_n_r ? -$signed({1'b0, cos_v_r}) : $signed({1'b0, cos_v_r});
  end

  always_ff @(posedge clk) begin
    pr_r <= h1_r * cos_s;
    pi_r <= h1_r * sin_s;
  end

  // Accumulate the real and imaginary sums.
  logic signed [ACC_W-1:0] re_r;
  logic signed [ACC_W-1:0] im_r;

  always_ff @(posedge clk) begin
    if (cmd.pt_init) begin
      re_r <= '0;
      im_r <= '0;
    end else if (v2_r) begin
      re_r <= re_r + ACC_W'(pr_r);
      im_r <= im_r - ACC_W'(pi_r);
    end
  end

  // Round each absolute sum to Q20, then square.
  logic [ACC_W-1:0] re_abs;
  logic [ACC_W-1:0] im_abs;
  logic [ACC_W-1:0] re_rnd;
  logic [ACC_W-1:0] im_rnd;
  logic [AMW-1:0]   a_full;
  logic [AMW-1:0]   b_full;
  logic [31:0]      a_r;
  logic [31:0]      b_r;
  logic [63:0]      a2_r;
  logic [63:0]      b2_r;
  logic             sat_r;
  logic [64:0]      sum_sq;
  logic [31:0]      root;
  logic             root_busy;

  always_comb begin
    re_abs = re_r[ACC_W-1] ? ACC_W'(-re_r) : ACC_W'(re_r);
    im_abs = im_r[ACC_W-1] ? ACC_W'(-im_r) : ACC_W'(im_r);
    re_rnd = re_abs + (ACC_W'(1) << 26);
    im_rnd = im_abs + (ACC_W'(1) << 26);
    a_full = re_rnd[ACC_W-1:27];
    b_full = im_rnd[ACC_W-1:27];
    sum_sq = {1'b0, a2_r} + {1'b0, b2_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      a_r   <= 32'(a_full);
      b_r   <= 32'(b_full);
      sat_r <= (|(a_full >> 32)) || (|(b_full >> 32));
    end else if (cmd.root_start) begin
      sat_r <= sat_r || sum_sq[64];
    end
    if (cmd.sq) begin
      a2_r <= a_r * a_r;
      b2_r <= b_r * b_r;
    end
  end

  spn_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_start),
    .x     (sum_sq[63:0]),
    .busy  (root_busy),
    .root  (root)
  );

  // Peak tracking and the geometric grid step.
  logic [MAG_W-1:0] peak_r;
  logic [GW-1:0]    grid_r;
  logic [MAG_W-1:0] mag_val;
  logic [63:0]      step_prod;
  logic [31:0]      step_nxt;

  always_comb begin
    mag_val   = sat_r ? '1 : root;
    step_prod = 64'(step_r) * 64'(ratio_r) + (64'd1 << 29);
    step_nxt  = (|step_prod[63:62]) ? '1 : step_prod[61:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (cmd.an_init) begin
      peak_r <= '0;
    end else if (cmd.pt_done && (mag_val > peak_r)) begin
      peak_r <= mag_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.an_init) begin
      step_r <= step0_r;
      grid_r <= '0;
    end else if (cmd.pt_done) begin
      step_r <= step_nxt;
      grid_r <= grid_r + GW'(1);
    end
  end

  // Gain = round(2^44 / peak), saturated, unity for a zero peak.
  logic [44:0]       quot;
  logic              div_busy;
  logic [GAIN_W-1:0] gain_r;

  spn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (peak_r),
    .busy    (div_busy),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_UNITY;
    end else if (cmd.gain_load) begin
      if (peak_r == '0) begin
        gain_r <= GAIN_UNITY;
      end else if (|quot[44:32]) begin
        gain_r <= '1;
      end else begin
        gain_r <= quot[31:0];
      end
    end
  end

  // Read path: scale the stored sample by the gain, round and saturate.
  logic                       rd_ok_r;
  logic signed [RP_W-1:0]     rp_r;
  logic [RP_W-1:0]            rp_abs;
  logic [RP_W-1:0]            rp_rnd;
  logic [RP_W-25:0]           mr;
  logic signed [SAMPLE_W-1:0] rd_val;

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rd_ok_r <= IXW'(in_index) < IXW'(count_r);
    end
    if (cmd.rd_mul) begin
      rp_r <= mem_q_r * $signed({1'b0, gain_r});
    end
  end

  always_comb begin
    rp_abs = rp_r[RP_W-1] ? RP_W'(-rp_r) : RP_W'(rp_r);
    rp_rnd = rp_abs + (RP_W'(1) << 23);
    mr     = rp_rnd[RP_W-1:24];
    if (!rd_ok_r) begin
      rd_val = '0;
    end else if (rp_r[RP_W-1]) begin
      rd_val = (mr > (RP_W-24)'(24'h80_0000)) ? $signed(24'h80_0000)
                                              : $signed(24'(-mr));
    end else begin
      rd_val = (mr > (RP_W-24)'(24'h7F_FFFF)) ? $signed(24'h7F_FFFF)
                                              : $signed(mr[SAMPLE_W-1:0]);
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.out_read) begin
      out_result_kind <= KIND_SAMPLE;
      out_peak_mag    <= peak_r;
      out_gain        <= gain_r;
      out_sample      <= rd_val;
    end else if (cmd.out_an) begin
      out_result_kind <= KIND_DONE;
      out_peak_mag    <= peak_r;
      out_gain        <= gain_r;
      out_sample      <= '0;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.tap_last  = {1'b0, tap_n_r} == (count_r - CW'(1));
    sts.pipe_busy = v0_r || v1_r || v2_r;
    sts.root_busy = root_busy;
    sts.grid_last = grid_r == GW'(GRID_POINTS - 1);
    sts.div_busy  = div_busy;
  end

endmodule

// ===== hw/rtl/spn_ctrl.sv =====
// Controller: sequences loads, reads, the grid analysis and the result register.
module spn_ctrl import spn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  input  logic     in_last,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  output spn_cmd_t cmd,
  input  spn_sts_t sts
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000_0000_0000_0001,
    S_RD_MUL    = 15'b000_0000_0000_0010,
    S_RD_OUT    = 15'b000_0000_0000_0100,
    S_AN_START  = 15'b000_0000_0000_1000,
    S_AN_RUN    = 15'b000_0000_0001_0000,
    S_AN_DRAIN  = 15'b000_0000_0010_0000,
    S_AN_MAG    = 15'b000_0000_0100_0000,
    S_AN_SQ     = 15'b000_0000_1000_0000,
    S_ROOT_GO   = 15'b000_0001_0000_0000,
    S_ROOT      = 15'b000_0010_0000_0000,
    S_AN_NEXT   = 15'b000_0100_0000_0000,
    S_DIV_GO    = 15'b000_1000_0000_0000,
    S_DIV       = 15'b001_0000_0000_0000,
    S_AN_OUT    = 15'b010_0000_0000_0000,
    S_SPARE     = 15'b100_0000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != S_IDLE;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_READ) begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_RD_MUL;
          end else begin
            cmd.load = 1'b1;
            if (in_last) begin
              state_nxt = S_AN_START;
            end
          end
        end
      end
      S_RD_MUL: begin
        cmd.rd_mul = 1'b1;
        state_nxt  = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (out_free) begin
          cmd.out_read = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_AN_START: begin
        cmd.an_init = 1'b1;
        cmd.pt_init = 1'b1;
        state_nxt   = S_AN_RUN;
      end
      S_AN_RUN: begin
        cmd.issue = 1'b1;
        if (sts.tap_last) begin
          state_nxt = S_AN_DRAIN;
        end
      end
      S_AN_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_AN_MAG;
        end
      end
      S_AN_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_AN_SQ;
      end
      S_AN_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT;
      end
      S_ROOT: begin
        if (!sts.root_busy) begin
          state_nxt = S_AN_NEXT;
        end
      end
      S_AN_NEXT: begin
        cmd.pt_done = 1'b1;
        cmd.pt_init = 1'b1;
        state_nxt   = sts.grid_last ? S_DIV_GO : S_AN_RUN;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.gain_load = 1'b1;
          state_nxt     = S_AN_OUT;
        end
      end
      S_AN_OUT: begin
        if (out_free) begin
          cmd.out_an = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid: set on a load, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_read || cmd.out_an) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/spn_checker.sv =====
// Port-level checker for the spectral peak normalizer and its bind.
`include "spectral_peak_normalizer_defines.svh"

module spn_checker import spn_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_result_kind,
  input logic [MAG_W-1:0]           out_peak_mag,
  input logic [GAIN_W-1:0]          out_gain,
  input logic signed [SAMPLE_W-1:0] out_sample
);

  logic rd_take;
  logic done_out;
  logic zero_pk;

  // Conditions observed on the ports.
  assign rd_take  = in_valid && !in_stall && (in_cmd == CMD_READ);
  assign done_out = out_valid && (out_result_kind == KIND_DONE);
  assign zero_pk  = out_valid && (out_peak_mag == '0);

  // A stalled result stays offered.
  `SPN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // A read transaction occupies the block for the following cycle.
  `SPN_ASSERT_NEXT(a_read_busy, rd_take, in_stall, "read not followed by stall")

  // An analysis result carries no sample.
  `SPN_ASSERT_NOW(a_done_zero, done_out, out_sample == '0, "analysis result with sample")

  // A zero peak always comes with unity gain.
  `SPN_ASSERT_NOW(a_zero_unity, zero_pk, out_gain == GAIN_UNITY, "zero peak without unity gain")

endmodule

bind spectral_peak_normalizer spn_checker u_spn_checker (.*);

// ===== verif/spectral_peak_normalizer_test.sv =====
// Self-checking testbench of the spectral peak normalizer with its own peak and gain tracker.
module spectral_peak_normalizer_test;
  import spn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS = 2048;
  localparam int POINTS = 512;
  localparam int DEPTH = 1024;
  localparam longint CYCLE_LIMIT = 40_000_000;

  // One expected result transaction.
  typedef struct {
    logic                       kind;
    logic [MAG_W-1:0]           peak;
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] value;
  } norm_result_t;

  // Tracks the stored response, the peak and the gain, and checks every result.
  class peak_gain_tracker;
    longint        sine_tab[DEPTH+1];
    logic [31:0]   step0;
    logic [30:0]   ratio;
    longint        taps[TAPS];
    int unsigned   tap_count;
    logic [31:0]   peak_now;
    logic [31:0]   gain_now;
    bit            closed;
    norm_result_t  expected_results[$];
    int            errors;

    function new();
      longint unsigned th, t2, f, s;
      step0 = FIRST_STEP_RST;
      ratio = GRID_RATIO_RST;
      tap_count = 0;
      peak_now = 0;
      gain_now = GAIN_UNITY;
      closed = 0;
      errors = 0;
      // Quarter-wave sine table by a truncated Taylor series.
      for (int i = 0; i <= DEPTH; i++) begin
        th = (longint'(i) * HALF_PI_Q30 + DEPTH / 2) / DEPTH;
        t2 = (th * th) >> 30;
        f = ONE_Q30;
        for (int k = 6; k >= 1; k--)
          f = ONE_Q30 - ((t2 * f) >> 30) / longint'((2 * k) * (2 * k + 1));
        s = (th * f) >> 30;
        if (s > ONE_Q30) s = ONE_Q30;
        s = (s + 32) >> 6;
        if (s > ONE_Q24) s = ONE_Q24;
        sine_tab[i] = s;
      end
    endfunction

    function void configure(logic idx, logic [31:0] data);
      if (idx == REG_FIRST_STEP) step0 = data;
      else ratio = data[30:0];
    endfunction

    function longint sine_of(logic [31:0] phase);
      longint unsigned pos;
      longint v;
      pos = (longint'(phase[29:0]) * DEPTH + (64'd1 << 29)) >> 30;
      if (pos > DEPTH) pos = DEPTH;
      v = phase[30] ? sine_tab[DEPTH - pos] : sine_tab[pos];
      return phase[31] ? -v : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [31:0] magnitude_at(logic [31:0] step);
      longint re, im;
      longint unsigned a, b, a2, b2;
      logic [31:0] phase;
      re = 0;
      im = 0;
      phase = 0;
      for (int n = 0; n < tap_count; n++) begin
        re += taps[n] * sine_of(phase + 32'h4000_0000);
        im -= taps[n] * sine_of(phase);
        phase += step;
      end
      a = ((re < 0 ? -re : re) + (64'd1 << 26)) >> 27;
      b = ((im < 0 ? -im : im) + (64'd1 << 26)) >> 27;
      if (a > 64'hFFFF_FFFF || b > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      a2 = a * a;
      b2 = b * b;
      if (a2 > ~b2) return 32'hFFFF_FFFF;
      a = int_sqrt(a2 + b2);
      return a > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : a[31:0];
    endfunction

    // Sweeps the geometric grid and derives the peak and the gain.
    function void run_analysis();
      longint unsigned step, q;
      logic [31:0] pk, m;
      step = step0;
      pk = 0;
      for (int k = 0; k < POINTS; k++) begin
        m = magnitude_at(step[31:0]);
        if (m > pk) pk = m;
        step = (step * ratio + (64'd1 << 29)) >> 30;
        if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
      end
      peak_now = pk;
      if (pk == 0) begin
        gain_now = GAIN_UNITY;
      end else begin
        q = ((64'd1 << 44) + pk / 2) / pk;
        gain_now = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
      end
    endfunction

    // Notes one accepted input transaction.
    function void note_input(logic cmd, logic signed [SAMPLE_W-1:0] smp, logic lst,
                             logic [IDX_W-1:0] idx);
      norm_result_t r;
      longint prod;
      longint unsigned m;
      if (cmd == CMD_LOAD) begin
        if (closed) begin
          tap_count = 0;
          closed = 0;
        end
        if (tap_count < TAPS) begin
          taps[tap_count] = smp;
          tap_count++;
        end
        if (!lst) return;
        run_analysis();
        closed = 1;
        r.kind = KIND_DONE;
        r.value = 0;
      end else begin
        r.kind = KIND_SAMPLE;
        r.value = 0;
        if (idx < tap_count) begin
          prod = taps[idx] * longint'({32'd0, gain_now});
          m = ((prod < 0 ? -prod : prod) + (64'd1 << 23)) >> 24;
          if (prod < 0) r.value = m > 64'h80_0000 ? -24'sd8388608 : -m;
          else r.value = m > 64'h7F_FFFF ? 24'sd8388607 : m;
        end
      end
      r.peak = peak_now;
      r.gain = gain_now;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    // Compares one accepted result with the oldest expectation.
    task check_result(logic kind, logic [MAG_W-1:0] pk, logic [GAIN_W-1:0] gn,
                      logic signed [SAMPLE_W-1:0] val);
      norm_result_t e;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, kind", kind, -1);
        return;
      end
      e = expected_results.pop_front();
      if (kind !== e.kind) report_mismatch("result_kind", kind, e.kind);
      if (pk !== e.peak) report_mismatch("peak_mag", pk, e.peak);
      if (gn !== e.gain) report_mismatch("gain", gn, e.gain);
      if (val !== e.value) report_mismatch("out_sample", val, e.value);
    endtask
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_cmd;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_last;
  logic [IDX_W-1:0]           in_index;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_result_kind;
  logic [MAG_W-1:0]           out_peak_mag;
  logic [GAIN_W-1:0]          out_gain;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  peak_gain_tracker tracker = new();
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     hold_cycles = 0;
  longint cycle_count = 0;
  int     written_top = 0;

  spectral_peak_normalizer DUT (.*);

  // Clock.
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("spectral_peak_normalizer_test NOT OK");
      $finish;
    end
  end

  // Receiver stall, with a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Input and result monitors.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_input(in_cmd, in_sample, in_last, in_index);
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_result_kind, out_peak_mag, out_gain, out_sample);
    if (rst_n && cfg_valid && cfg_ready) tracker.configure(cfg_index, cfg_data);
  end

  task automatic send(logic cmd, logic signed [SAMPLE_W-1:0] smp, logic lst,
                      logic [IDX_W-1:0] idx);
    in_valid <= 1;
    in_cmd <= cmd;
    in_sample <= smp;
    in_last <= lst;
    in_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load(logic signed [SAMPLE_W-1:0] smp, logic lst);
    send(CMD_LOAD, smp, lst, IDX_W'($urandom));
    if (tracker.tap_count > written_top) written_top = tracker.tap_count;
  endtask

  task automatic read_at(logic [IDX_W-1:0] idx, logic lst = 0);
    send(CMD_READ, SAMPLE_W'($urandom), lst, idx);
  endtask

  task automatic wait_drain();
    in_valid <= 0;
    @(posedge clk);
    while (tracker.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
    wait_drain();
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // Random sample, often small so that gains vary widely.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
      1: return SAMPLE_W'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One response with random content, then reads, some of them during loading.
  task automatic random_response();
    int n, reads;
    n = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    reads = $urandom_range(10, 20);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0)
        read_at(IDX_W'($urandom_range(0, written_top - 1)), 1'($urandom));
      load(rand_sample(), i == n - 1);
    end
    for (int i = 0; i < reads; i++) begin
      if ($urandom_range(3) == 0)
        read_at(IDX_W'($urandom_range(0, written_top - 1)), 1'($urandom));
      else read_at(IDX_W'($urandom_range(0, tracker.tap_count - 1)), 1'($urandom));
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_cmd = CMD_LOAD;
    in_sample = 0;
    in_last = 0;
    in_index = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = REG_FIRST_STEP;
    cfg_data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Full store: the extra load is dropped but its last flag runs the analysis.
    for (int i = 0; i <= TAPS; i++) load(rand_sample(), i == TAPS);
    read_at(0);
    read_at(TAPS - 1);
    read_at(1234, 1);

    // All-zero response gives a zero peak and unity gain.
    load(0, 1);
    read_at(0);
    read_at(5);

    // Sample extremes and a read beyond the response.
    load(24'sh7F_FFFF, 0);
    load(-24'sd8388608, 1);
    read_at(0);
    read_at(1);
    read_at(2);

    // Tiny peak saturates the gain; reads during loading then saturate.
    load(16, 1);
    read_at(0);
    load(24'sh7F_FFFF, 0);
    read_at(0);
    load(-24'sd8388608, 0);
    read_at(1);
    read_at(2047);
    load(1, 1);
    read_at(2);

    // Receiver holds off while the sender keeps offering reads.
    wait_drain();
    hold_cycles = 400;
    for (int i = 0; i < 40; i++) read_at(IDX_W'($urandom_range(0, 2)));
    wait_drain();

    // Random phases with different idling and register settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin
          send_idle_pct = 84; stall_pct = 0;
          write_reg(REG_FIRST_STEP, 32'd0);
          write_reg(REG_GRID_RATIO, 32'h4000_0000);
        end
        2: begin
          send_idle_pct = 0; stall_pct = 84;
          write_reg(REG_FIRST_STEP, 32'hFFFF_FFFF);
          write_reg(REG_GRID_RATIO, 32'h7FFF_FFFF);
        end
        default: begin
          send_idle_pct = 24; stall_pct = 24;
          write_reg(REG_FIRST_STEP, $urandom_range(100_000, 40_000_000));
          write_reg(REG_GRID_RATIO, $urandom_range(32'h4000_0000, 32'h4400_0000));
        end
      endcase
      for (int r = 0; r < 2; r++) random_response();
    end

    wait_drain();
    repeat (100) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("spectral_peak_normalizer_test OK");
    end else begin
      $display("spectral_peak_normalizer_test NOT OK");
    end
    $finish;
  end
endmodule
